FILE: hdl/ekht_pkg.sv
// shared constants, codes and types of the edge key hash table
package ekht_pkg;

  localparam int ID_W       = 20;
  localparam int VAL_W      = 31;
  localparam int KEY_W      = 2 * ID_W;
  localparam int SLOT_W     = KEY_W + VAL_W;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int RES_W      = 32;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  localparam int HASH_W   = 40;
  localparam int DIGIT_W  = 8;
  localparam int N_DIGITS = HASH_W / DIGIT_W;
  localparam int CNT_W    = $clog2(N_DIGITS);

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_HASH     = 9'b000000100,
    S_MOD      = 9'b000001000,
    S_FREAD    = 9'b000010000,
    S_DISPATCH = 9'b000100000,
    S_SCAN     = 9'b001000000,
    S_MOVE     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  typedef struct packed {
    logic              found;
    logic [RES_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

FILE: hdl/ekht_ram.sv
// generic single write port ram with registered read
module ekht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/edge_key_hash_table_unit.sv
// edge key hash table: bucketed slot store with lookup, insert and remove
//
// One request is worked at a time. An insert passes the hash, modulo, fill read, dispatch
// and done states before its result is presented. A lookup or remove also scans the bucket's
// filled slots (at most SLOTS_PER_BUCKET) between dispatch and done. A remove that hits before
// the bucket's last slot goes through a move state that copies that last slot into the gap. The
// next input beat can be accepted in the same cycle that the result is presented. The hash
// modulo unit reduces eight hash bits per cycle over five digits, and the single read port of
// the slot memory yields one slot per cycle. After reset the block walks the fill memory to
// zero it, while in_tready stays low. A finished result waits in the output register while
// the next beat is accepted.
module edge_key_hash_table_unit #(
  parameter int BUCKETS          = 1024,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // src_vertex, dst_vertex, new_value
  input  logic [ekht_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  logic [ekht_pkg::REQ_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // found, result_value, status
  output logic [ekht_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import ekht_pkg::*;

  localparam int BUCKET_AW  = $clog2(BUCKETS);
  localparam int SLOT_DEPTH = BUCKETS * SLOTS_PER_BUCKET;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int FILL_W     = $clog2(SLOTS_PER_BUCKET + 1);
  localparam logic [BUCKET_AW:0]   BUCKETS_EXT = (BUCKET_AW + 1)'(BUCKETS);
  localparam logic [BUCKET_AW-1:0] LAST_BUCKET = BUCKET_AW'(BUCKETS - 1);
  localparam logic [FILL_W-1:0]    SLOTS_MAX   = FILL_W'(SLOTS_PER_BUCKET);

  function automatic logic [BUCKET_AW-1:0] mod_digit(input logic [BUCKET_AW-1:0] r,
                                                     input logic [DIGIT_W-1:0] d);
    logic [BUCKET_AW:0]   t;
    logic [BUCKET_AW-1:0] acc;
    acc = r;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {acc, d[i]};
      if (t >= BUCKETS_EXT) begin
        t = t - BUCKETS_EXT;
      end
      acc = t[BUCKET_AW-1:0];
    end
    return acc;
  endfunction

  state_t               state_r, state_nxt;
  logic [BUCKET_AW-1:0] clr_r, clr_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [ID_W-1:0]      src_r, src_nxt;
  logic [ID_W-1:0]      dst_r, dst_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [31:0]          h1_r, h1_nxt;
  logic [ID_W-1:0]      hi_r, hi_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [BUCKET_AW-1:0] rem_r, rem_nxt;
  logic [SLOT_AW-1:0]   base_r, base_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [FILL_W-1:0]    idx_r, idx_nxt;
  result_t              res_r, res_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                 fill_we, fill_re;
  logic [BUCKET_AW-1:0] fill_waddr;
  logic [FILL_W-1:0]    fill_wdata, fill_rdata;
  logic                 slot_we, slot_re;
  logic [SLOT_AW-1:0]   slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
  logic [FILL_W-1:0]    slot_ridx;

  logic [ID_W-1:0]      in_src, in_dst, in_lo;
  logic [KEY_W-1:0]     key_fwd, key_rev, slot_key;
  logic [FILL_W-1:0]    last_idx;
  logic                 hit_any, hit_fwd;

  assign in_src   = in_tdata[ID_W-1:0];
  assign in_dst   = in_tdata[2*ID_W-1:ID_W];
  assign in_lo    = (in_src < in_dst) ? in_src : in_dst;
  assign key_fwd  = {src_r, dst_r};
  assign key_rev  = {dst_r, src_r};
  assign slot_key = slot_rdata[SLOT_W-1 -: KEY_W];
  assign last_idx = fill_r - FILL_W'(1);
  assign hit_any  = (slot_key == key_fwd) || (slot_key == key_rev);
  assign hit_fwd  = (slot_key == key_fwd);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    if (state_r == S_SCAN) begin
      slot_ridx = (req_r == REQ_REMOVE && hit_fwd) ? last_idx : idx_r + FILL_W'(1);
    end else begin
      slot_ridx = '0;
    end
  end

  assign slot_raddr = base_r + SLOT_AW'(slot_ridx);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    req_nxt        = req_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    val_nxt        = val_r;
    h1_nxt         = h1_r;
    hi_nxt         = hi_r;
    hash_nxt       = hash_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    base_nxt       = base_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    fill_we        = 1'b0;
    fill_re        = 1'b0;
    fill_waddr     = rem_r;
    fill_wdata     = '0;
    slot_we        = 1'b0;
    slot_re        = 1'b0;
    slot_waddr     = base_r + SLOT_AW'(idx_r);
    slot_wdata     = slot_rdata;

    case (state_r)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        if (clr_r == LAST_BUCKET) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + BUCKET_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt   = in_tuser;
          src_nxt   = in_src;
          dst_nxt   = in_dst;
          val_nxt   = in_tdata[2*ID_W+VAL_W-1:2*ID_W];
          hi_nxt    = (in_src < in_dst) ? in_dst : in_src;
          h1_nxt    = (32'(in_lo) + GOLDEN + 32'd64) ^ 32'd1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        hash_nxt  = HASH_W'(h1_r) ^ (HASH_W'(hi_r) + HASH_W'(GOLDEN)
                    + {2'b00, h1_r, 6'b000000} + HASH_W'(h1_r[31:2]));
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        rem_nxt  = mod_digit(rem_r, hash_r[HASH_W-1 -: DIGIT_W]);
        hash_nxt = hash_r << DIGIT_W;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(N_DIGITS - 1)) begin
          state_nxt = S_FREAD;
        end
      end
      S_FREAD: begin
        fill_re   = 1'b1;
        base_nxt  = SLOT_AW'(rem_r) * SLOT_AW'(SLOTS_PER_BUCKET);
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        fill_nxt       = fill_rdata;
        idx_nxt        = '0;
        res_nxt.found  = 1'b0;
        res_nxt.value  = '1;
        res_nxt.status = (req_r == REQ_REMOVE) ? ST_NOT_FOUND : ST_OK;
        state_nxt      = S_DONE;
        case (req_r)
          REQ_LOOKUP, REQ_REMOVE: begin
            if (fill_rdata != '0) begin
              slot_re   = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          REQ_INSERT: begin
            if (fill_rdata >= SLOTS_MAX) begin
              res_nxt.status = ST_FULL;
            end else begin
              slot_we    = 1'b1;
              slot_waddr = base_r + SLOT_AW'(fill_rdata);
              slot_wdata = {key_fwd, val_r};
              fill_we    = 1'b1;
              fill_wdata = fill_rdata + FILL_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (req_r == REQ_LOOKUP && hit_any) begin
          res_nxt.found = 1'b1;
          res_nxt.value = {1'b0, slot_rdata[VAL_W-1:0]};
          state_nxt     = S_DONE;
        end else if (req_r == REQ_REMOVE && hit_fwd) begin
          res_nxt.found  = 1'b1;
          res_nxt.status = ST_OK;
          if (idx_r == last_idx) begin
            fill_we    = 1'b1;
            fill_wdata = last_idx;
            state_nxt  = S_DONE;
          end else begin
            slot_re   = 1'b1;
            state_nxt = S_MOVE;
          end
        end else if (idx_r + FILL_W'(1) == fill_r) begin
          state_nxt = S_DONE;
        end else begin
          slot_re = 1'b1;
          idx_nxt = idx_r + FILL_W'(1);
        end
      end
      S_MOVE: begin
        slot_we    = 1'b1;
        fill_we    = 1'b1;
        fill_wdata = last_idx;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(OUT_DATA_W - RES_W - STAT_W - 1)'(0),
                            res_r.status, res_r.value, res_r.found};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    val_r       <= val_nxt;
    h1_r        <= h1_nxt;
    hi_r        <= hi_nxt;
    hash_r      <= hash_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    base_r      <= base_nxt;
    fill_r      <= fill_nxt;
    idx_r       <= idx_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // fill count of each bucket
  ekht_ram #(
    .WIDTH (FILL_W),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (rem_r),
    .rdata (fill_rdata)
  );

  // key and value of each slot
  ekht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

endmodule

FILE: test/tb_edge_key_hash_table_unit.sv
// self-checking testbench of the edge key hash table with stalls on both stream sides
module tb_edge_key_hash_table_unit;
  import ekht_pkg::*;

  localparam int BUCKETS = 1024;
  localparam int SLOTS = 8;
  localparam int HOT_BUCKETS = 6;
  localparam int HOT_KEYS = 12;
  localparam int RANDOM_REQS = 1800;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [RES_W-1:0] NO_VALUE = '1;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  src;
    logic [ID_W-1:0]  dst;
    logic [VAL_W-1:0] val;
  } edge_req_t;

  typedef struct {
    logic              found;
    logic [RES_W-1:0]  value;
    logic [STAT_W-1:0] status;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [REQ_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  edge_key_hash_table_unit #(
    .BUCKETS(BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  logic [KEY_W-1:0] shadow_keys[BUCKETS*SLOTS];
  logic [VAL_W-1:0] shadow_vals[BUCKETS*SLOTS];
  int unsigned shadow_fill[BUCKETS];

  edge_req_t pending_reqs[$];
  table_reply_t predicted_replies[$];
  logic [KEY_W-1:0] key_history[$];
  logic [KEY_W-1:0] hot_keys[HOT_BUCKETS][HOT_KEYS];

  int n_total = 0;
  int n_sent = 0;
  int n_errors = 0;
  int send_gap = 0;
  int recv_hold = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned bucket_index(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
    logic [63:0] lo, hi, h;
    lo = (a < b) ? 64'(a) : 64'(b);
    hi = (a < b) ? 64'(b) : 64'(a);
    h = 64'd1;
    h = h ^ (lo + {32'd0, GOLDEN} + (h << 6) + (h >> 2));
    h = h ^ (hi + {32'd0, GOLDEN} + (h << 6) + (h >> 2));
    return int'(h % 64'(BUCKETS));
  endfunction

  function automatic table_reply_t table_apply(edge_req_t r);
    table_reply_t rep;
    int unsigned b, base, fill;
    logic [KEY_W-1:0] fwd, rev;
    rep.found = 1'b0;
    rep.value = NO_VALUE;
    rep.status = ST_OK;
    b = bucket_index(r.src, r.dst);
    base = b * SLOTS;
    fill = shadow_fill[b];
    fwd = {r.src, r.dst};
    rev = {r.dst, r.src};
    case (r.req)
      REQ_LOOKUP: begin
        for (int i = 0; i < fill; i++) begin
          if (shadow_keys[base+i] == fwd || shadow_keys[base+i] == rev) begin
            rep.found = 1'b1;
            rep.value = {1'b0, shadow_vals[base+i]};
            break;
          end
        end
      end
      REQ_INSERT: begin
        if (fill >= SLOTS) begin
          rep.status = ST_FULL;
        end else begin
          shadow_keys[base+fill] = fwd;
          shadow_vals[base+fill] = r.val;
          shadow_fill[b] = fill + 1;
        end
      end
      REQ_REMOVE: begin
        rep.status = ST_NOT_FOUND;
        for (int i = 0; i < fill; i++) begin
          if (shadow_keys[base+i] == fwd) begin
            shadow_keys[base+i] = shadow_keys[base+fill-1];
            shadow_vals[base+i] = shadow_vals[base+fill-1];
            shadow_fill[b] = fill - 1;
            rep.found = 1'b1;
            rep.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(int unsigned target);
    logic [ID_W-1:0] s, d;
    s = ID_W'($urandom);
    d = ID_W'($urandom);
    while (bucket_index(s, d) != target) d = d + 1'b1;
    return {s, d};
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 59) == 0) calm = ~calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(0, 7))
      0: return ID_W'($urandom_range(0, 15));
      1: return ID_MAX - ID_W'($urandom_range(0, 15));
      default: return ID_W'($urandom);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return VAL_MAX;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] src, logic [ID_W-1:0] dst,
                         logic [VAL_W-1:0] val);
    edge_req_t r;
    r.req = req;
    r.src = src;
    r.dst = dst;
    r.val = val;
    pending_reqs.push_back(r);
    if (req == REQ_INSERT) key_history.push_back({src, dst});
  endtask

  task automatic add_known(logic [REQ_W-1:0] req, logic [KEY_W-1:0] k, bit swap);
    if (swap) add_req(req, k[ID_W-1:0], k[KEY_W-1:ID_W], rand_val());
    else add_req(req, k[KEY_W-1:ID_W], k[ID_W-1:0], rand_val());
  endtask

  task automatic report_mismatch(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
    n_errors++;
    $display("mismatch on %s at beat %0d: got %0h, want %0h", what, n_sent, got, want);
  endtask

  // stimulus, then wait for the last reply to drain
  initial begin
    logic [KEY_W-1:0] k;
    int r;
    for (int h = 0; h < HOT_BUCKETS; h++) begin
      r = $urandom_range(0, BUCKETS - 1);
      for (int j = 0; j < HOT_KEYS; j++) hot_keys[h][j] = key_in_bucket(r);
    end
    add_req(REQ_LOOKUP, '0, '0, '0);
    add_req(REQ_REMOVE, '0, '0, '0);
    add_req(REQ_INSERT, '0, '0, '0);
    add_req(REQ_INSERT, ID_MAX, ID_MAX, VAL_MAX);
    add_req(REQ_LOOKUP, ID_MAX, ID_MAX, '0);
    add_req(REQ_LOOKUP, '0, '0, VAL_MAX);
    add_req(REQ_INSERT, 20'd3, ID_MAX, 31'h2aaaaaaa);
    add_req(REQ_LOOKUP, ID_MAX, 20'd3, '0);
    add_req(REQ_REMOVE, ID_MAX, 20'd3, '0);
    add_req(REQ_INSERT, '0, '0, 31'h55555555);
    add_req(REQ_LOOKUP, '0, '0, '0);
    add_req(REQ_REMOVE, '0, '0, '0);
    add_req(REQ_LOOKUP, '0, '0, '0);
    for (int j = 0; j <= SLOTS; j++) add_known(REQ_INSERT, hot_keys[0][j], 1'b0);
    add_known(REQ_REMOVE, hot_keys[0][2], 1'b0);
    add_known(REQ_LOOKUP, hot_keys[0][SLOTS-1], 1'b1);
    add_known(REQ_LOOKUP, hot_keys[0][2], 1'b0);
    add_req(REQ_UNUSED, 20'd3, ID_MAX, VAL_MAX);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        r = $urandom_range(0, 9);
        if (r < 5)
          k = hot_keys[$urandom_range(0, HOT_BUCKETS - 1)][$urandom_range(0, HOT_KEYS - 1)];
        else if (r < 8) k = {rand_id(), rand_id()};
        else k = key_history[$urandom_range(0, key_history.size() - 1)];
        add_known(REQ_INSERT, k, 1'b0);
      end else if (r < 65) begin
        if ($urandom_range(0, 3) != 0) k = key_history[$urandom_range(0, key_history.size() - 1)];
        else k = {rand_id(), rand_id()};
        add_known(REQ_LOOKUP, k, 1'($urandom_range(0, 1)));
      end else if (r < 90) begin
        r = $urandom_range(0, 19);
        if (r < 17) k = key_history[$urandom_range(0, key_history.size() - 1)];
        else k = {rand_id(), rand_id()};
        add_known(REQ_REMOVE, k, (r >= 14 && r < 17));
      end else if (r < 93) begin
        add_req(REQ_UNUSED, rand_id(), rand_id(), rand_val());
      end else begin
        add_req(REQ_W'($urandom_range(0, 2)), rand_id(), rand_id(), rand_val());
      end
    end
    n_total = pending_reqs.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (n_sent < n_total || predicted_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    edge_req_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        r.req = in_tuser;
        r.src = in_tdata[ID_W-1:0];
        r.dst = in_tdata[2*ID_W-1:ID_W];
        r.val = in_tdata[2*ID_W+VAL_W-1:2*ID_W];
        predicted_replies.push_back(table_apply(r));
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          r = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= r.req;
          in_tdata <= {1'b0, r.val, r.dst, r.src};
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected beat", RES_W'(out_tdata), '0);
        end else begin
          want = predicted_replies.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch("found", RES_W'(out_tdata[0]), RES_W'(want.found));
          if (out_tdata[RES_W:1] !== want.value)
            report_mismatch("result_value", out_tdata[RES_W:1], want.value);
          if (out_tdata[RES_W+STAT_W:RES_W+1] !== want.status)
            report_mismatch("status", RES_W'(out_tdata[RES_W+STAT_W:RES_W+1]),
                            RES_W'(want.status));
        end
        recv_hold = pick_gap();
      end else if (recv_hold == 0 && $urandom_range(0, 19) == 0) begin
        recv_hold = pick_gap();
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
